FILE: rtl/core/xbt_pkg.sv
// Shared types, opcode constants and byte-level helpers for the x86 branch
// target and reference classifier. No dependencies.
`default_nettype none

package xbt_pkg;

    localparam int unsigned ADDR_BITS   = 32;
    localparam int unsigned WINDOW_BITS = 56;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_JUMP = 2'd1;
    localparam logic [1:0] KIND_CALL = 2'd2;

    localparam logic [1:0] TBL_NONE   = 2'd0;
    localparam logic [1:0] TBL_IJUMP  = 2'd1;
    localparam logic [1:0] TBL_ICALL  = 2'd2;
    localparam logic [1:0] TBL_LOAD   = 2'd3;

    localparam logic [7:0] OP_PFX_ES    = 8'h26;
    localparam logic [7:0] OP_PFX_CS    = 8'h2e;
    localparam logic [7:0] OP_PFX_SS    = 8'h36;
    localparam logic [7:0] OP_PFX_DS    = 8'h3e;
    localparam logic [7:0] OP_PFX_FS    = 8'h64;
    localparam logic [7:0] OP_PFX_GS    = 8'h65;
    localparam logic [7:0] OP_PFX_OPSZ  = 8'h66;
    localparam logic [7:0] OP_PFX_ADSZ  = 8'h67;
    localparam logic [7:0] OP_TWO_BYTE  = 8'h0f;
    localparam logic [7:0] OP_JMP_REL8  = 8'heb;
    localparam logic [7:0] OP_CALL_REL  = 8'he8;
    localparam logic [7:0] OP_JMP_REL   = 8'he9;
    localparam logic [7:0] OP_GRP5      = 8'hff;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8b;
    localparam logic [7:0] OP_MOV_LOAD8 = 8'h8a;
    localparam logic [7:0] OP_TEST      = 8'h85;
    localparam logic [7:0] OP_MOVZX     = 8'hb6;
    localparam logic [7:0] OP_MOV_IMM   = 8'hc7;
    localparam logic [7:0] OP_GRP1      = 8'h81;
    localparam logic [7:0] OP_PUSH_IMM  = 8'h68;

    localparam logic [2:0] REG_ICALL = 3'd2;
    localparam logic [2:0] REG_IJUMP = 3'd4;
    localparam logic [2:0] REG_MOV   = 3'd0;
    localparam logic [2:0] REG_CMP   = 3'd7;

    localparam logic [1:0] MOD_NONE  = 2'd0;
    localparam logic [1:0] MOD_D32   = 2'd2;
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_D32    = 3'd5;

    localparam logic [3:0] LEN_REL8  = 4'd2;
    localparam logic [3:0] LEN_REL32 = 4'd5;
    localparam logic [3:0] LEN_JCC32 = 4'd6;

    typedef struct packed {
        logic [1:0]           branch_kind;
        logic [ADDR_BITS-1:0] branch_target;
        logic [1:0]           table_access;
        logic                 imm_mem_ref;
    } result_t;

    function automatic logic is_seg_prefix(input logic [7:0] b);
        return (b == OP_PFX_ES) || (b == OP_PFX_CS) || (b == OP_PFX_SS) ||
               (b == OP_PFX_DS) || (b == OP_PFX_FS) || (b == OP_PFX_GS);
    endfunction

    function automatic logic has_disp32(input logic [7:0] modrm, input logic [7:0] sib);
        return (modrm[7:6] == MOD_D32) ||
               ((modrm[7:6] == MOD_NONE) && (modrm[2:0] == RM_D32)) ||
               ((modrm[7:6] == MOD_NONE) && (modrm[2:0] == RM_SIB) &&
                (sib[2:0] == RM_D32));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xbt_decode.sv
// Combinational decode of one instruction window into branch, table and
// immediate classes. Depends on xbt_pkg.
`default_nettype none

module xbt_decode (
    input  wire logic [xbt_pkg::ADDR_BITS-1:0]   instr_addr,
    input  wire logic [xbt_pkg::WINDOW_BITS-1:0] instr_window,
    output xbt_pkg::result_t                     result
);

    logic [7:0]  b0;
    logic        seg;
    logic        br_pfx;
    logic [7:0]  op1;
    logic [7:0]  op2;
    logic [31:0] rel32_a;
    logic [31:0] rel32_b;
    logic [31:0] disp;
    logic [3:0]  len;
    logic [1:0]  kind;
    logic [7:0]  t_op;
    logic [7:0]  t_modrm;
    logic [7:0]  t_sib;
    logic [7:0]  t_modrm2;
    logic [7:0]  t_sib2;
    logic        t_d32;
    logic [1:0]  tbl;
    logic        imm;

    assign b0     = instr_window[7:0];
    assign seg    = xbt_pkg::is_seg_prefix(b0);
    assign br_pfx = seg || (b0 == xbt_pkg::OP_PFX_OPSZ) || (b0 == xbt_pkg::OP_PFX_ADSZ);

    assign op1     = br_pfx ? instr_window[15:8]  : instr_window[7:0];
    assign op2     = br_pfx ? instr_window[23:16] : instr_window[15:8];
    assign rel32_a = br_pfx ? instr_window[47:16] : instr_window[39:8];
    assign rel32_b = br_pfx ? instr_window[55:24] : instr_window[47:16];

    always_comb
    begin
        kind = xbt_pkg::KIND_NONE;
        len  = xbt_pkg::LEN_REL8;
        disp = {{24{op2[7]}}, op2};
        if (((op1 >= 8'he0) && (op1 <= 8'he3)) || (op1 == xbt_pkg::OP_JMP_REL8) ||
            ((op1 >= 8'h70) && (op1 <= 8'h7f)))
        begin
            kind = xbt_pkg::KIND_JUMP;
        end
        else if (op1 == xbt_pkg::OP_CALL_REL)
        begin
            kind = xbt_pkg::KIND_CALL;
            len  = xbt_pkg::LEN_REL32;
            disp = rel32_a;
        end
        else if (op1 == xbt_pkg::OP_JMP_REL)
        begin
            kind = xbt_pkg::KIND_JUMP;
            len  = xbt_pkg::LEN_REL32;
            disp = rel32_a;
        end
        else if ((op1 == xbt_pkg::OP_TWO_BYTE) && (op2[7:4] == 4'h8))
        begin
            kind = xbt_pkg::KIND_JUMP;
            len  = xbt_pkg::LEN_JCC32;
            disp = rel32_b;
        end
    end

    assign t_op     = seg ? instr_window[15:8]  : instr_window[7:0];
    assign t_modrm  = seg ? instr_window[23:16] : instr_window[15:8];
    assign t_sib    = seg ? instr_window[31:24] : instr_window[23:16];
    assign t_modrm2 = seg ? instr_window[31:24] : instr_window[23:16];
    assign t_sib2   = seg ? instr_window[39:32] : instr_window[31:24];
    assign t_d32    = xbt_pkg::has_disp32(t_modrm, t_sib);

    always_comb
    begin
        tbl = xbt_pkg::TBL_NONE;
        if (t_op == xbt_pkg::OP_GRP5)
        begin
            if (t_d32 && (t_modrm[5:3] == xbt_pkg::REG_IJUMP))
                tbl = xbt_pkg::TBL_IJUMP;
            else if (t_d32 && (t_modrm[5:3] == xbt_pkg::REG_ICALL))
                tbl = xbt_pkg::TBL_ICALL;
        end
        else if ((t_op == xbt_pkg::OP_MOV_LOAD) || (t_op == xbt_pkg::OP_MOV_LOAD8) ||
                 (t_op == xbt_pkg::OP_TEST))
        begin
            if (t_d32)
                tbl = xbt_pkg::TBL_LOAD;
        end
        else if ((t_op == xbt_pkg::OP_TWO_BYTE) && (t_modrm == xbt_pkg::OP_MOVZX) &&
                 xbt_pkg::has_disp32(t_modrm2, t_sib2))
        begin
            tbl = xbt_pkg::TBL_LOAD;
        end
    end

    assign imm = ((t_op == xbt_pkg::OP_MOV_IMM) && t_d32 &&
                  (t_modrm[5:3] == xbt_pkg::REG_MOV)) ||
                 ((t_op == xbt_pkg::OP_GRP1) && t_d32 &&
                  (t_modrm[5:3] == xbt_pkg::REG_CMP)) ||
                 (t_op == xbt_pkg::OP_PUSH_IMM) || (t_op[7:3] == 5'b10111);

    always_comb
    begin
        result.branch_kind   = kind;
        result.branch_target = (kind == xbt_pkg::KIND_NONE) ? '0 :
                               instr_addr + {31'd0, br_pfx} + {28'd0, len} + disp;
        result.table_access  = tbl;
        result.imm_mem_ref   = imm;
    end

endmodule

`default_nettype wire

FILE: rtl/core/x86_branch_target_and_ref_classifier.sv
// Top level of the x86 branch target and reference classifier: input
// register, decode and result register. Depends on xbt_pkg and xbt_decode.
//
// Channel  | Direction | tdata contents (lowest bit first)
// s_axis   | in        | instr_addr[31:0], instr_window[87:32]
// m_axis   | out       | branch_kind[1:0], branch_target[33:2], table_access[35:34],
//          |           | imm_mem_ref[36], zero fill[39:37]
//
// One transfer is accepted per cycle while m_axis does not stall; each result is
// registered in the input register and then in the result register around the
// decode logic. Reset clears both valid flags only. When m_axis stalls, the
// result register holds and the input register can still take one more item.
`default_nettype none

module x86_branch_target_and_ref_classifier #(
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,   // instr_addr, instr_window
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // branch_kind, branch_target, table_access,
                                             // imm_mem_ref, zero fill
);

    localparam int unsigned TGT_W = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

    logic                             in_valid_reg;
    logic [xbt_pkg::ADDR_BITS-1:0]    addr_reg;
    logic [xbt_pkg::WINDOW_BITS-1:0]  window_reg;
    logic                             out_valid_reg;
    logic [1:0]                       kind_reg;
    logic [TGT_W-1:0]                 target_reg;
    logic [1:0]                       table_reg;
    logic                             imm_reg;
    logic                             out_ready;
    logic                             in_ready;
    xbt_pkg::result_t                 result;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_ready      = !in_valid_reg || out_ready;
    assign s_axis_tready = in_ready;

    xbt_decode u_decode (
        .instr_addr   (addr_reg),
        .instr_window (window_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= s_axis_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            addr_reg   <= s_axis_tdata[31:0];
            window_reg <= s_axis_tdata[87:32];
        end
        if (out_ready && in_valid_reg)
        begin
            kind_reg   <= result.branch_kind;
            target_reg <= result.branch_target[TGT_W-1:0];
            table_reg  <= result.table_access;
            imm_reg    <= result.imm_mem_ref;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, imm_reg, table_reg, 32'(target_reg), kind_reg};

endmodule

`default_nettype wire
